### rtl/kdltc_pkg.sv
`default_nettype none

package kdltc_pkg;

    // Default sizes
    localparam int CHUNK_BYTES_DEF  = 256;
    localparam int KNOCK_LENGTH_DEF = 8;

    // Test length limits and option defaults
    localparam logic [16:0] COUNT_MAX     = 17'd65536;
    localparam logic [7:0]  MODE_RX       = "R";
    localparam logic [7:0]  MODE_DEFAULT  = "T";
    localparam logic [15:0] DELAY_DEFAULT = 16'd2;
    localparam logic [7:0]  SEQ_MASK      = 8'hFF;

    // Knock patterns, first byte in the top lane
    localparam logic [63:0] PAT_PROG = "ADHTPROG";
    localparam logic [63:0] PAT_DIAG = "ADHTDIAG";
    localparam logic [63:0] PAT_LINK = "ADHTUART";

    typedef enum logic [1:0] {
        PH_SCAN = 2'd0,
        PH_OPTS = 2'd1,
        PH_RX   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_PROG      = 3'd1,
        EV_DIAG      = 3'd2,
        EV_TX_TEST   = 3'd3,
        EV_RX_REPORT = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        KN_PROG = 2'd0,
        KN_DIAG = 2'd1,
        KN_LINK = 2'd2
    } knock_t;

    typedef struct packed {
        logic [3:0] len;
        logic       hit;
    } match_t;

    // Pattern byte at a position; positions past the eighth read as zero
    function automatic logic [7:0] pattern_byte(knock_t k, logic [3:0] idx);
        logic [63:0] pat;
        logic [7:0]  r;
        case (k)
            KN_PROG: pat = PAT_PROG;
            KN_DIAG: pat = PAT_DIAG;
            KN_LINK: pat = PAT_LINK;
            default: pat = '0;
        endcase
        if (idx[3])
            r = 8'h00;
        else
            r = pat[8 * (7 - idx[2:0]) +: 8];
        return r;
    endfunction

    // One matcher step with naive restart on a miss
    function automatic match_t match_advance(knock_t k, logic [3:0] len, logic [7:0] b,
                                             logic [4:0] knock_len);
        logic [4:0] inc;
        match_t     r;
        inc = {1'b0, len} + 5'd1;
        if (b == pattern_byte(k, len)) begin
            r.len = inc[3:0];
            r.hit = (inc >= knock_len);
        end
        else begin
            r.len = (b == pattern_byte(k, 4'd0)) ? 4'd1 : 4'd0;
            r.hit = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/knock_detector_and_link_test_checker.sv
`default_nettype none

// Channel   | Direction | Handshake         | Payload
// ----------+-----------+-------------------+-----------------------------------------------
// input     | in        | in_valid/in_stall | op, rx_byte
// result    | out       | out_valid/out_stall| event_res, chunk_delay_ms, bytes_received,
//           |           |                   | error_count, first_bad_*
// config    | in        | cfg_we            | cfg_wdata (test_byte_count)
//
// Every accepted transaction yields exactly one result, registered in the next cycle.
// Throughput is one transaction per cycle unless stalled: matchers, option capture and
// the chunk check all resolve in a single combinational pass into the result register.
// in_stall is high only while the result register holds a transaction that the
// downstream side is stalling; a result taken in the same cycle frees the slot.
// rst_n clears all scan/test state, the output valid, and sets test_byte_count to 65536.

module knock_detector_and_link_test_checker #(
    parameter int CHUNK_BYTES  = kdltc_pkg::CHUNK_BYTES_DEF,
    parameter int KNOCK_LENGTH = kdltc_pkg::KNOCK_LENGTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [7:0]  rx_byte,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       event_res,
    output logic [15:0]      chunk_delay_ms,
    output logic [16:0]      bytes_received,
    output logic [16:0]      error_count,
    output logic             first_bad_valid,
    output logic [15:0]      first_bad_index,
    output logic [7:0]       first_bad_expected,
    output logic [7:0]       first_bad_got,

    input  wire logic        cfg_we,
    input  wire logic [16:0] cfg_wdata
);

    localparam int FILL_W = $clog2(CHUNK_BYTES + 1);
    localparam logic [16:0] CHUNK_SIZE = 17'(CHUNK_BYTES);
    localparam logic [4:0]  KNOCK_LEN  = 5'(KNOCK_LENGTH);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [16:0]       test_byte_count_reg;

    kdltc_pkg::phase_t phase_reg, phase_next;
    logic [3:0]        prog_len_reg, prog_len_next;
    logic [3:0]        diag_len_reg, diag_len_next;
    logic [3:0]        link_len_reg, link_len_next;
    logic [1:0]        opt_count_reg, opt_count_next;
    logic [7:0]        mode_reg, mode_next;
    logic [15:0]       delay_reg, delay_next;

    // Committed receive-test totals
    logic [16:0]       verified_reg, verified_next;
    logic [16:0]       err_total_reg, err_total_next;
    logic              fv_reg, fv_next;
    logic [15:0]       fidx_reg, fidx_next;
    logic [7:0]        fexp_reg, fexp_next;
    logic [7:0]        fgot_reg, fgot_next;

    // Current (uncommitted) chunk
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] cerr_reg, cerr_next;
    logic              cfv_reg, cfv_next;
    logic [15:0]       cfidx_reg, cfidx_next;
    logic [7:0]        cfexp_reg, cfexp_next;
    logic [7:0]        cfgot_reg, cfgot_next;

    // Result register
    logic              out_valid_reg;
    logic [2:0]        event_reg, event_next;
    logic [15:0]       delay_out_reg, delay_out_next;
    logic [16:0]       rcvd_out_reg, rcvd_out_next;
    logic [16:0]       errs_out_reg, errs_out_next;
    logic              fv_out_reg, fv_out_next;
    logic [15:0]       fidx_out_reg, fidx_out_next;
    logic [7:0]        fexp_out_reg, fexp_out_next;
    logic [7:0]        fgot_out_reg, fgot_out_next;

    logic accept;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    // ------------------------------------------------------------------
    // Knock matchers
    // ------------------------------------------------------------------
    kdltc_pkg::match_t prog_m, diag_m, link_m;

    assign prog_m = kdltc_pkg::match_advance(kdltc_pkg::KN_PROG, prog_len_reg, rx_byte,
                                             KNOCK_LEN);
    assign diag_m = kdltc_pkg::match_advance(kdltc_pkg::KN_DIAG, diag_len_reg, rx_byte,
                                             KNOCK_LEN);
    assign link_m = kdltc_pkg::match_advance(kdltc_pkg::KN_LINK, link_len_reg, rx_byte,
                                             KNOCK_LEN);

    // ------------------------------------------------------------------
    // Option capture: final mode/delay as seen by the finishing step
    // ------------------------------------------------------------------
    logic [7:0]  opt_mode;
    logic [15:0] opt_delay;
    logic        opt_done;

    always_comb
    begin
        opt_mode  = mode_reg;
        opt_delay = delay_reg;
        if (!op) begin
            case (opt_count_reg)
                2'd0:    opt_mode  = rx_byte;
                2'd1:    opt_delay = {delay_reg[15:8], rx_byte};
                default: opt_delay = {rx_byte, delay_reg[7:0]};
            endcase
        end
    end

    assign opt_done = op | (opt_count_reg == 2'd2);

    // ------------------------------------------------------------------
    // Receive check datapath
    // ------------------------------------------------------------------
    logic [16:0]       cnt_eff, remaining, chunk_size, verified_commit, err_commit;
    logic [15:0]       pos;
    logic [7:0]        exp_byte;
    logic              mismatch, rem_zero, chunk_full, rx_done;
    logic [FILL_W-1:0] fill_inc, cerr_inc;
    logic              cfv_new;
    logic [15:0]       cfidx_new;
    logic [7:0]        cfexp_new, cfgot_new;
    logic              fv_commit;
    logic [15:0]       fidx_commit;
    logic [7:0]        fexp_commit, fgot_commit;

    always_comb
    begin
        // Zero behaves as one, anything past 64 KiB is clamped
        if (test_byte_count_reg == 17'd0)
            cnt_eff = 17'd1;
        else if (test_byte_count_reg > kdltc_pkg::COUNT_MAX)
            cnt_eff = kdltc_pkg::COUNT_MAX;
        else
            cnt_eff = test_byte_count_reg;
    end

    assign remaining  = (cnt_eff > verified_reg) ? cnt_eff - verified_reg : 17'd0;
    assign rem_zero   = (remaining == 17'd0);
    assign chunk_size = (remaining > CHUNK_SIZE) ? CHUNK_SIZE : remaining;

    assign pos      = verified_reg[15:0] + 16'(fill_reg);
    assign exp_byte = pos[7:0] & kdltc_pkg::SEQ_MASK;
    assign mismatch = (rx_byte != exp_byte);

    assign fill_inc = fill_reg + FILL_W'(1);
    assign cerr_inc = cerr_reg + FILL_W'(mismatch);

    // Chunk's first mismatch after this byte
    assign cfv_new   = cfv_reg | mismatch;
    assign cfidx_new = cfv_reg ? cfidx_reg : (mismatch ? pos      : cfidx_reg);
    assign cfexp_new = cfv_reg ? cfexp_reg : (mismatch ? exp_byte : cfexp_reg);
    assign cfgot_new = cfv_reg ? cfgot_reg : (mismatch ? rx_byte  : cfgot_reg);

    // A chunk that already holds the remaining count commits with what it holds
    assign chunk_full      = (17'(fill_inc) >= chunk_size);
    assign verified_commit = verified_reg + 17'(fill_inc);
    assign err_commit      = err_total_reg + 17'(cerr_inc);
    assign rx_done         = chunk_full & (verified_commit >= cnt_eff);

    assign fv_commit   = fv_reg | cfv_new;
    assign fidx_commit = fv_reg ? fidx_reg : cfidx_new;
    assign fexp_commit = fv_reg ? fexp_reg : cfexp_new;
    assign fgot_commit = fv_reg ? fgot_reg : cfgot_new;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next     = phase_reg;
        prog_len_next  = prog_len_reg;
        diag_len_next  = diag_len_reg;
        link_len_next  = link_len_reg;
        opt_count_next = opt_count_reg;
        mode_next      = mode_reg;
        delay_next     = delay_reg;
        verified_next  = verified_reg;
        err_total_next = err_total_reg;
        fv_next        = fv_reg;
        fidx_next      = fidx_reg;
        fexp_next      = fexp_reg;
        fgot_next      = fgot_reg;
        fill_next      = fill_reg;
        cerr_next      = cerr_reg;
        cfv_next       = cfv_reg;
        cfidx_next     = cfidx_reg;
        cfexp_next     = cfexp_reg;
        cfgot_next     = cfgot_reg;

        case (phase_reg)
            kdltc_pkg::PH_SCAN:
            begin
                // Timeouts while scanning leave the matchers alone
                if (!op) begin
                    if (prog_m.hit || diag_m.hit || link_m.hit) begin
                        prog_len_next = 4'd0;
                        diag_len_next = 4'd0;
                        link_len_next = 4'd0;
                        if (!prog_m.hit && !diag_m.hit) begin
                            phase_next     = kdltc_pkg::PH_OPTS;
                            opt_count_next = 2'd0;
                            mode_next      = kdltc_pkg::MODE_DEFAULT;
                            delay_next     = kdltc_pkg::DELAY_DEFAULT;
                        end
                    end
                    else begin
                        prog_len_next = prog_m.len;
                        diag_len_next = diag_m.len;
                        link_len_next = link_m.len;
                    end
                end
            end

            kdltc_pkg::PH_OPTS:
            begin
                mode_next  = opt_mode;
                delay_next = opt_delay;
                if (!op)
                    opt_count_next = opt_done ? 2'd0 : opt_count_reg + 2'd1;
                if (opt_done) begin
                    if (opt_mode == kdltc_pkg::MODE_RX) begin
                        phase_next     = kdltc_pkg::PH_RX;
                        verified_next  = 17'd0;
                        err_total_next = 17'd0;
                        fv_next        = 1'b0;
                        fidx_next      = 16'd0;
                        fexp_next      = 8'd0;
                        fgot_next      = 8'd0;
                        fill_next      = '0;
                        cerr_next      = '0;
                        cfv_next       = 1'b0;
                        cfidx_next     = 16'd0;
                        cfexp_next     = 8'd0;
                        cfgot_next     = 8'd0;
                    end
                    else begin
                        phase_next = kdltc_pkg::PH_SCAN;
                    end
                end
            end

            kdltc_pkg::PH_RX:
            begin
                if (op || rem_zero) begin
                    phase_next    = kdltc_pkg::PH_SCAN;
                    prog_len_next = 4'd0;
                    diag_len_next = 4'd0;
                    link_len_next = 4'd0;
                end
                else if (chunk_full) begin
                    verified_next  = verified_commit;
                    err_total_next = err_commit;
                    fv_next        = fv_commit;
                    fidx_next      = fidx_commit;
                    fexp_next      = fexp_commit;
                    fgot_next      = fgot_commit;
                    fill_next      = '0;
                    cerr_next      = '0;
                    cfv_next       = 1'b0;
                    cfidx_next     = 16'd0;
                    cfexp_next     = 8'd0;
                    cfgot_next     = 8'd0;
                    if (rx_done) begin
                        phase_next    = kdltc_pkg::PH_SCAN;
                        prog_len_next = 4'd0;
                        diag_len_next = 4'd0;
                        link_len_next = 4'd0;
                    end
                end
                else begin
                    fill_next  = fill_inc;
                    cerr_next  = cerr_inc;
                    cfv_next   = cfv_new;
                    cfidx_next = cfidx_new;
                    cfexp_next = cfexp_new;
                    cfgot_next = cfgot_new;
                end
            end

            default:
            begin
                phase_next = kdltc_pkg::PH_SCAN;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result
    // ------------------------------------------------------------------
    always_comb
    begin
        event_next     = kdltc_pkg::EV_NONE;
        delay_out_next = 16'd0;
        rcvd_out_next  = 17'd0;
        errs_out_next  = 17'd0;
        fv_out_next    = 1'b0;
        fidx_out_next  = 16'd0;
        fexp_out_next  = 8'd0;
        fgot_out_next  = 8'd0;

        case (phase_reg)
            kdltc_pkg::PH_SCAN:
            begin
                if (!op) begin
                    if (prog_m.hit)
                        event_next = kdltc_pkg::EV_PROG;
                    else if (diag_m.hit)
                        event_next = kdltc_pkg::EV_DIAG;
                end
            end

            kdltc_pkg::PH_OPTS:
            begin
                if (opt_done && (opt_mode != kdltc_pkg::MODE_RX)) begin
                    event_next     = kdltc_pkg::EV_TX_TEST;
                    delay_out_next = opt_delay;
                end
            end

            kdltc_pkg::PH_RX:
            begin
                if (op || rem_zero) begin
                    // Partial chunk dropped, committed totals reported
                    event_next    = kdltc_pkg::EV_RX_REPORT;
                    rcvd_out_next = verified_reg;
                    errs_out_next = err_total_reg;
                    fv_out_next   = fv_reg;
                    fidx_out_next = fidx_reg;
                    fexp_out_next = fexp_reg;
                    fgot_out_next = fgot_reg;
                end
                else if (rx_done) begin
                    event_next    = kdltc_pkg::EV_RX_REPORT;
                    rcvd_out_next = verified_commit;
                    errs_out_next = err_commit;
                    fv_out_next   = fv_commit;
                    fidx_out_next = fidx_commit;
                    fexp_out_next = fexp_commit;
                    fgot_out_next = fgot_commit;
                end
            end

            default:
            begin
                event_next = kdltc_pkg::EV_NONE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            test_byte_count_reg <= kdltc_pkg::COUNT_MAX;
        end
        else if (cfg_we) begin
            test_byte_count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= kdltc_pkg::PH_SCAN;
            prog_len_reg  <= 4'd0;
            diag_len_reg  <= 4'd0;
            link_len_reg  <= 4'd0;
            opt_count_reg <= 2'd0;
            mode_reg      <= kdltc_pkg::MODE_DEFAULT;
            delay_reg     <= kdltc_pkg::DELAY_DEFAULT;
            verified_reg  <= 17'd0;
            err_total_reg <= 17'd0;
            fv_reg        <= 1'b0;
            fidx_reg      <= 16'd0;
            fexp_reg      <= 8'd0;
            fgot_reg      <= 8'd0;
            fill_reg      <= '0;
            cerr_reg      <= '0;
            cfv_reg       <= 1'b0;
            cfidx_reg     <= 16'd0;
            cfexp_reg     <= 8'd0;
            cfgot_reg     <= 8'd0;
        end
        else if (accept) begin
            phase_reg     <= phase_next;
            prog_len_reg  <= prog_len_next;
            diag_len_reg  <= diag_len_next;
            link_len_reg  <= link_len_next;
            opt_count_reg <= opt_count_next;
            mode_reg      <= mode_next;
            delay_reg     <= delay_next;
            verified_reg  <= verified_next;
            err_total_reg <= err_total_next;
            fv_reg        <= fv_next;
            fidx_reg      <= fidx_next;
            fexp_reg      <= fexp_next;
            fgot_reg      <= fgot_next;
            fill_reg      <= fill_next;
            cerr_reg      <= cerr_next;
            cfv_reg       <= cfv_next;
            cfidx_reg     <= cfidx_next;
            cfexp_reg     <= cfexp_next;
            cfgot_reg     <= cfgot_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (accept) begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            event_reg     <= event_next;
            delay_out_reg <= delay_out_next;
            rcvd_out_reg  <= rcvd_out_next;
            errs_out_reg  <= errs_out_next;
            fv_out_reg    <= fv_out_next;
            fidx_out_reg  <= fidx_out_next;
            fexp_out_reg  <= fexp_out_next;
            fgot_out_reg  <= fgot_out_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign event_res          = event_reg;
    assign chunk_delay_ms     = delay_out_reg;
    assign bytes_received     = rcvd_out_reg;
    assign error_count        = errs_out_reg;
    assign first_bad_valid    = fv_out_reg;
    assign first_bad_index    = fidx_out_reg;
    assign first_bad_expected = fexp_out_reg;
    assign first_bad_got      = fgot_out_reg;

endmodule

`default_nettype wire

### bench/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kdltc_pkg::*;

    // Input transaction kinds
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    localparam int KNOCK_LEN      = KNOCK_LENGTH_DEF;
    localparam int CHUNK_LEN      = CHUNK_BYTES_DEF;
    localparam int IDLE_LIMIT     = 1000;   // cycles with no transaction on either side
    localparam int TOTAL_ITEMS    = 1750;   // random traffic tops the run up to this
    localparam int RX_CAP         = 300;    // longest random receive run

    // One result transaction, in port order
    typedef struct packed {
        event_t      ev;
        logic [15:0] delay;
        logic [16:0] nbytes;
        logic [16:0] nerrors;
        logic        bad_valid;
        logic [15:0] bad_index;
        logic [7:0]  bad_want;
        logic [7:0]  bad_got;
    } link_result_t;

    // First mismatch record
    typedef struct packed {
        logic        valid;
        logic [15:0] index;
        logic [7:0]  want;
        logic [7:0]  got;
    } bad_rec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = OP_BYTE;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  event_res;
    logic [15:0] chunk_delay_ms;
    logic [16:0] bytes_received;
    logic [16:0] error_count;
    logic        first_bad_valid;
    logic [15:0] first_bad_index;
    logic [7:0]  first_bad_expected;
    logic [7:0]  first_bad_got;
    logic        cfg_we = 1'b0;
    logic [16:0] cfg_wdata = 17'd0;

    knock_detector_and_link_test_checker uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .op                 (op),
        .rx_byte            (rx_byte),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .event_res          (event_res),
        .chunk_delay_ms     (chunk_delay_ms),
        .bytes_received     (bytes_received),
        .error_count        (error_count),
        .first_bad_valid    (first_bad_valid),
        .first_bad_index    (first_bad_index),
        .first_bad_expected (first_bad_expected),
        .first_bad_got      (first_bad_got),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: mirrors the block, starts at its reset values
    // ------------------------------------------------------------------
    logic [3:0]  scan_prog = 4'd0;
    logic [3:0]  scan_diag = 4'd0;
    logic [3:0]  scan_link = 4'd0;
    phase_t      link_phase = PH_SCAN;
    int          opts_taken = 0;
    logic [7:0]  opt_mode = MODE_DEFAULT;
    logic [15:0] opt_delay = DELAY_DEFAULT;
    logic [16:0] byte_count_reg = COUNT_MAX;
    logic [16:0] rx_done = 17'd0;
    int          rx_fill = 0;
    logic [16:0] rx_err_total = 17'd0;
    int          rx_chunk_err = 0;
    bad_rec_t    bad_committed = '0;
    bad_rec_t    bad_chunk = '0;

    link_result_t pending_results[$];

    int gap_max = 4;          // upper bound of idle cycles drawn per transaction
    int stall_left = 0;
    int idle_cycles = 0;
    int mismatch_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int ev_tally [5] = '{0, 0, 0, 0, 0};

    // Pattern byte; positions past the eighth read as zero
    function automatic logic [7:0] knock_char(logic [63:0] word, int pos);
        if (pos >= 8)
            return 8'h00;
        return 8'(word >> (8 * (7 - pos)));
    endfunction

    // Naive-restart matcher; returns 1 on a full knock
    function automatic bit knock_advance(inout logic [3:0] depth, input logic [63:0] word,
                                         input logic [7:0] b);
        int nxt;
        if (b == knock_char(word, depth)) begin
            nxt = depth + 1;
            depth = nxt[3:0];
            return nxt >= KNOCK_LEN;
        end
        depth = (b == knock_char(word, 0)) ? 4'd1 : 4'd0;
        return 1'b0;
    endfunction

    function automatic int eff_byte_count();
        if (byte_count_reg == 17'd0)
            return 1;
        if (byte_count_reg > COUNT_MAX)
            return 65536;
        return byte_count_reg;
    endfunction

    function automatic void clear_scanners();
        scan_prog = 4'd0;
        scan_diag = 4'd0;
        scan_link = 4'd0;
    endfunction

    function automatic void clear_rx_chunk();
        rx_fill = 0;
        rx_chunk_err = 0;
        bad_chunk = '0;
    endfunction

    function automatic void report_rx(inout link_result_t r);
        r.ev = EV_RX_REPORT;
        r.nbytes = rx_done;
        r.nerrors = rx_err_total;
        r.bad_valid = bad_committed.valid;
        r.bad_index = bad_committed.index;
        r.bad_want = bad_committed.want;
        r.bad_got = bad_committed.got;
        link_phase = PH_SCAN;
        clear_scanners();
    endfunction

    // Options done: 'R' opens a receive test, anything else asks for a transmit test
    function automatic void close_options(inout link_result_t r);
        if (opt_mode == MODE_RX) begin
            link_phase = PH_RX;
            rx_done = 17'd0;
            rx_err_total = 17'd0;
            bad_committed = '0;
            clear_rx_chunk();
        end
        else begin
            r.ev = EV_TX_TEST;
            r.delay = opt_delay;
            link_phase = PH_SCAN;
            clear_scanners();
        end
    endfunction

    // Expected result of one accepted input transaction; advances the state
    function automatic link_result_t predict_link(logic op_i, logic [7:0] b);
        link_result_t r;
        int cnt;
        int remaining;
        int size;
        int pos;
        logic [7:0] want;
        r = '0;
        case (link_phase)
            PH_SCAN: begin
                // timeouts are dropped here and matcher progress survives them
                if (op_i == OP_BYTE) begin
                    if (knock_advance(scan_prog, PAT_PROG, b)) begin
                        clear_scanners();
                        r.ev = EV_PROG;
                    end
                    else if (knock_advance(scan_diag, PAT_DIAG, b)) begin
                        clear_scanners();
                        r.ev = EV_DIAG;
                    end
                    else if (knock_advance(scan_link, PAT_LINK, b)) begin
                        clear_scanners();
                        link_phase = PH_OPTS;
                        opts_taken = 0;
                        opt_mode = MODE_DEFAULT;
                        opt_delay = DELAY_DEFAULT;
                    end
                end
            end
            PH_OPTS: begin
                if (op_i == OP_TIMEOUT)
                    close_options(r);
                else begin
                    case (opts_taken)
                        0:       opt_mode = b;
                        1:       opt_delay[7:0] = b;
                        default: opt_delay[15:8] = b;
                    endcase
                    opts_taken++;
                    if (opts_taken >= 3) begin
                        opts_taken = 0;
                        close_options(r);
                    end
                end
            end
            default: begin
                if (op_i == OP_TIMEOUT)
                    report_rx(r);     // partial chunk is thrown away
                else begin
                    cnt = eff_byte_count();
                    remaining = (cnt > rx_done) ? cnt - rx_done : 0;
                    if (remaining == 0)
                        report_rx(r); // count lowered under what was taken: no check
                    else begin
                        size = (remaining > CHUNK_LEN) ? CHUNK_LEN : remaining;
                        pos = rx_done + rx_fill;
                        want = pos[7:0];
                        if (b != want) begin
                            rx_chunk_err++;
                            if (!bad_chunk.valid)
                                bad_chunk = '{1'b1, pos[15:0], want, b};
                        end
                        rx_fill++;
                        // commit only whole chunks; a short last chunk counts as whole
                        if (rx_fill >= size) begin
                            rx_done = 17'(rx_done + rx_fill);
                            rx_err_total = 17'(rx_err_total + rx_chunk_err);
                            if (!bad_committed.valid && bad_chunk.valid)
                                bad_committed = bad_chunk;
                            clear_rx_chunk();
                            if (rx_done >= cnt)
                                report_rx(r);
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall, compare against oldest expectation
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        link_result_t want;
        if (out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing pending, event_res %0d", event_res);
                mismatch_count++;
            end
            else begin
                want = pending_results.pop_front();
                check_field("event_res", want.ev, event_res);
                check_field("chunk_delay_ms", want.delay, chunk_delay_ms);
                check_field("bytes_received", want.nbytes, bytes_received);
                check_field("error_count", want.nerrors, error_count);
                check_field("first_bad_valid", want.bad_valid, first_bad_valid);
                check_field("first_bad_index", want.bad_index, first_bad_index);
                check_field("first_bad_expected", want.bad_want, first_bad_expected);
                check_field("first_bad_got", want.bad_got, first_bad_got);
                ev_tally[want.ev]++;
                checked_count++;
            end
            stall_left = $urandom_range(0, gap_max);
        end
        else if (out_valid && out_stall && stall_left > 0)
            stall_left--;
        out_stall <= (stall_left > 0);
    end

    // Watchdog: too long with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // One input transaction; returns in the cycle it was taken, valid still high
    task automatic send_item(logic op_v, logic [7:0] b);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= op_v;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
        pending_results.push_back(predict_link(op_v, b));
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(OP_BYTE, s[i]);
    endtask

    // Sender holds off until every pending result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_byte_count(logic [16:0] v);
        drain_results();
        repeat (2) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        byte_count_reg = v;
    endtask

    // Link knock, mode 'R', then a timeout to skip the delay bytes
    task automatic open_rx_test();
        send_text("ADHTUART");
        send_item(OP_BYTE, MODE_RX);
        send_item(OP_TIMEOUT, 8'h00);
    endtask

    // Receive-test bytes from the current position; bad_at forces one mismatch
    task automatic send_rx_run(int n, int bad_at, int err_pct);
        int pos;
        logic [7:0] v;
        for (int i = 0; i < n; i++) begin
            pos = rx_done + rx_fill;
            v = pos[7:0];
            if (pos == bad_at || $urandom_range(1, 100) <= err_pct)
                v = v ^ 8'($urandom_range(1, 255));
            send_item(OP_BYTE, v);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Program and diagnostic knocks, restart on 'A', timeout ignored mid-knock
    task automatic test_scan_knocks();
        send_text("ADH");
        send_item(OP_TIMEOUT, 8'hFF);
        send_text("TPROG");
        send_text("AADHTDIAG");
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
    endtask

    // Transmit request with full options, then with all defaults via timeout
    task automatic test_tx_request();
        send_text("ADHTUART");
        send_item(OP_BYTE, MODE_DEFAULT);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'hFF);
        send_text("ADHTUART");
        send_item(OP_TIMEOUT, 8'h00);
    endtask

    // Count extremes: zero acts as one, a one-byte tail chunk, timeout mid-chunk
    task automatic test_rx_counts();
        write_byte_count(17'd0);
        open_rx_test();
        send_rx_run(1, 0, 0);
        write_byte_count(17'd257);
        open_rx_test();
        send_rx_run(257, 256, 0);
        write_byte_count(COUNT_MAX);
        open_rx_test();
        send_rx_run(300, 270, 0);      // mismatch sits in the discarded partial chunk
        send_item(OP_TIMEOUT, 8'hA5);
    endtask

    // Count lowered while a receive test is open
    task automatic test_rx_lowered();
        write_byte_count(17'd600);
        open_rx_test();
        send_rx_run(260, 258, 0);
        write_byte_count(17'd258);     // partial chunk already past the new remainder
        send_rx_run(1, -1, 0);
        write_byte_count(17'd600);
        open_rx_test();
        send_rx_run(300, -1, 0);
        write_byte_count(17'd100);     // nothing left: next byte reports at once
        send_item(OP_BYTE, 8'h55);
    endtask

    // Over-range count clamps to 64K; every byte wrong, ended by a timeout
    task automatic test_over_range();
        write_byte_count(17'h1FFFF);
        gap_max = 1;
        open_rx_test();
        send_rx_run(260, -1, 100);
        send_item(OP_TIMEOUT, 8'h3C);
        gap_max = 4;
    endtask

    function automatic logic [16:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return 17'd0;
            1:       return 17'd1;
            2:       return 17'd256;
            3:       return 17'd257;
            4:       return COUNT_MAX;
            5:       return 17'h1FFFF;
            6:       return 17'($urandom_range(0, 17'h1FFFF));
            default: return 17'($urandom_range(1, RX_CAP));
        endcase
    endfunction

    task automatic rand_rx_body();
        int cnt;
        int cap;
        int n;
        int err_pct;
        cnt = eff_byte_count();
        cap = (cnt < RX_CAP) ? cnt : RX_CAP;
        case ($urandom_range(0, 4))
            0, 1:    err_pct = 0;
            2:       err_pct = 1;
            3:       err_pct = 25;
            default: err_pct = 100;
        endcase
        case ($urandom_range(0, 5))
            0: send_rx_run($urandom_range(0, cap), -1, err_pct);
            1: begin
                n = $urandom_range(0, cap);
                send_rx_run(n, -1, err_pct);
                write_byte_count(17'($urandom_range(0, n + 1)));
                while (link_phase == PH_RX)
                    send_rx_run(1, -1, err_pct);
            end
            default: send_rx_run((cnt <= RX_CAP) ? cnt : $urandom_range(1, cap), -1,
                                 err_pct);
        endcase
        if (link_phase == PH_RX)
            send_item(OP_TIMEOUT, 8'($urandom_range(0, 255)));
    endtask

    // Link knock (maybe with a dropped timeout inside), some options, then the test
    task automatic rand_link_session();
        string pat;
        int cut;
        int nopt;
        logic [7:0] mode;
        pat = "ADHTUART";
        if ($urandom_range(0, 3) == 0)
            write_byte_count(pick_count());
        cut = $urandom_range(0, 10);
        for (int i = 0; i < 8; i++) begin
            if (i == cut)
                send_item(OP_TIMEOUT, 8'($urandom_range(0, 255)));
            send_item(OP_BYTE, pat[i]);
        end
        if (link_phase != PH_OPTS)
            return;
        nopt = $urandom_range(0, 3);
        mode = ($urandom_range(0, 2) != 0) ? MODE_RX : 8'($urandom_range(0, 255));
        for (int i = 0; i < nopt; i++)
            send_item(OP_BYTE, (i == 0) ? mode : 8'($urandom_range(0, 255)));
        if (nopt < 3)
            send_item(OP_TIMEOUT, 8'($urandom_range(0, 255)));
        if (link_phase == PH_RX)
            rand_rx_body();
    endtask

    // Program/diagnostic knock, sometimes after a false start or with one byte broken
    task automatic rand_short_knock();
        string pat;
        int broken;
        pat = ($urandom_range(0, 1) != 0) ? "ADHTPROG" : "ADHTDIAG";
        if ($urandom_range(0, 2) == 0)
            for (int i = 0; i < $urandom_range(1, 7); i++)
                send_item(OP_BYTE, pat[i]);
        broken = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 8;
        for (int i = 0; i < 8; i++)
            send_item(OP_BYTE, (i == broken) ? 8'($urandom_range(0, 255)) : pat[i]);
    endtask

    // Line noise, heavy on knock letters
    task automatic rand_noise();
        string letters;
        letters = "ADHTPROGDIAUR";
        repeat ($urandom_range(1, 12))
            send_item(($urandom_range(0, 4) == 0) ? OP_TIMEOUT : OP_BYTE,
                      ($urandom_range(0, 1) != 0) ? letters[$urandom_range(0, 12)]
                                                  : 8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_traffic();
        int pick;
        while (sent_count < TOTAL_ITEMS) begin
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;   // some back-to-back stretches
            pick = $urandom_range(0, 19);
            if (pick < 3)
                rand_noise();
            else if (pick < 7)
                rand_short_knock();
            else
                rand_link_session();
        end
        gap_max = 4;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_scan_knocks();
        test_tx_request();
        test_rx_counts();
        test_rx_lowered();
        test_over_range();
        test_random_traffic();

        drain_results();
        repeat (4) @(posedge clk);

        $display("sent %0d input transactions, checked %0d results", sent_count,
                 checked_count);
        $display("program %0d, diagnostic %0d, transmit requests %0d, receive reports %0d",
                 ev_tally[EV_PROG], ev_tally[EV_DIAG], ev_tally[EV_TX_TEST],
                 ev_tally[EV_RX_REPORT]);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
rtl/kdltc_pkg.sv
rtl/knock_detector_and_link_test_checker.sv
bench/testbench.sv
